### sv/rc4sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared constants and types of the RC4 stream cipher engine.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

    // Permutation table geometry
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);

    typedef logic [PERM_AW-1:0] byte_t;

    localparam byte_t PERM_LAST = byte_t'(PERM_DEPTH - 1);

    // Key storage: two 64-bit words hold 16 key bytes
    localparam int KEY_SLOTS     = 16;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KIDX_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 2;

    typedef logic [KIDX_W-1:0] kidx_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LEN  = 2'd2;

    // Operation codes carried in tuser
    localparam logic OP_CRYPT = 1'b0;
    localparam logic OP_REKEY = 1'b1;

endpackage
`default_nettype wire

### sv/rc4sc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4sc_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rc4sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### sv/rc4_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// Crypt beat: taken in ST_IDLE; ST_C3 registers the result after ST_C1 and ST_C2
//   once the output slot frees. A new beat waits for ST_IDLE, as the single read
//   port of the permutation RAM serves two lookups and the keystream read in turn.
// Rekey beat: identity fill, then ST_K0 to ST_K3 for each entry, all before the next
//   input beat is taken; no output beat. Reset: a pass writes the identity permutation
//   before s_axis_tready rises; key registers reset to zero and key length to 5.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine around a 256x8 permutation RAM, driven by a small sequencer
// that reads, swaps and writes back one entry at a time.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [rc4sc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [rc4sc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] data_in
    input  wire logic                                s_axis_tuser,  // [0] opcode
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [7:0]                               m_axis_tdata   // [7:0] data_out
);

    localparam logic [3:0] ST_FILL = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_C1   = 4'd2;
    localparam logic [3:0] ST_C2   = 4'd3;
    localparam logic [3:0] ST_C3   = 4'd4;
    localparam logic [3:0] ST_K0   = 4'd5;
    localparam logic [3:0] ST_K1   = 4'd6;
    localparam logic [3:0] ST_K2   = 4'd7;
    localparam logic [3:0] ST_K3   = 4'd8;

    logic [3:0]                               state_reg, state_next;
    rc4sc_pkg::byte_t                         i_reg, i_next;
    rc4sc_pkg::byte_t                         j_reg, j_next;
    rc4sc_pkg::byte_t                         cnt_reg, cnt_next;
    rc4sc_pkg::kidx_t                         kidx_reg, kidx_next;
    logic                                     rekey_reg, rekey_next;
    rc4sc_pkg::byte_t                         si_reg, si_next;
    rc4sc_pkg::byte_t                         t_reg, t_next;
    logic                                     hit_reg, hit_next;
    rc4sc_pkg::byte_t                         hitval_reg, hitval_next;
    rc4sc_pkg::byte_t                         data_reg, data_next;
    logic                                     out_valid_reg, out_valid_next;
    rc4sc_pkg::byte_t                         out_data_reg, out_data_next;

    logic [rc4sc_pkg::CFG_DATA_W-1:0]         key_lo_reg;
    logic [rc4sc_pkg::CFG_DATA_W-1:0]         key_hi_reg;
    logic [rc4sc_pkg::KEY_LEN_W-1:0]          key_len_reg;

    logic                                     ram_we;
    rc4sc_pkg::byte_t                         ram_waddr;
    rc4sc_pkg::byte_t                         ram_wdata;
    rc4sc_pkg::byte_t                         ram_raddr;
    rc4sc_pkg::byte_t                         ram_rdata;

    logic [rc4sc_pkg::KEY_SLOTS-1:0][7:0]     key_bytes;
    rc4sc_pkg::kidx_t                         kidx_last;
    rc4sc_pkg::byte_t                         sum_t;
    logic                                     out_free;

    rc4sc_ram #(
        .WIDTH (rc4sc_pkg::PERM_AW),
        .DEPTH (rc4sc_pkg::PERM_DEPTH)
    ) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Key bytes and last key index of the cyclic key walk
    assign key_bytes = {key_hi_reg, key_lo_reg};

    always_comb
    begin
        priority if (key_len_reg == '0)
        begin
            kidx_last = '0;
        end
        else if (key_len_reg > rc4sc_pkg::KEY_LEN_W'(rc4sc_pkg::MAX_KEY_BYTES))
        begin
            kidx_last = rc4sc_pkg::KIDX_W'(rc4sc_pkg::MAX_KEY_BYTES - 1);
        end
        else
        begin
            kidx_last = rc4sc_pkg::KIDX_W'(key_len_reg - 1'b1);
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign sum_t         = si_reg + ram_rdata;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Sequencer: read, swap and write back the permutation
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        kidx_next      = kidx_reg;
        rekey_next     = rekey_reg;
        si_next        = si_reg;
        t_next         = t_reg;
        hit_next       = hit_reg;
        hitval_next    = hitval_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        ram_wdata      = cnt_reg;
        ram_raddr      = i_reg + 1'b1;

        unique case (state_reg)
            ST_FILL:
            begin
                // write entry k with k
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rc4sc_pkg::PERM_LAST)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = rekey_reg ? ST_K0 : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // fetch perm[i+1] speculatively; take the beat
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == rc4sc_pkg::OP_REKEY)
                    begin
                        i_next     = '0;
                        cnt_next   = '0;
                        rekey_next = 1'b1;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        data_next  = s_axis_tdata;
                        state_next = ST_C1;
                    end
                end
            end
            ST_C1:
            begin
                // advance j and fetch perm[j]
                si_next    = ram_rdata;
                j_next     = j_reg + ram_rdata;
                ram_raddr  = j_reg + ram_rdata;
                state_next = ST_C2;
            end
            ST_C2:
            begin
                // write perm[i] and fetch the keystream entry, forward pending swap
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = ram_rdata;
                ram_raddr = sum_t;
                t_next    = sum_t;
                priority if (sum_t == j_reg)
                begin
                    hit_next    = 1'b1;
                    hitval_next = si_reg;
                end
                else if (sum_t == i_reg)
                begin
                    hit_next    = 1'b1;
                    hitval_next = ram_rdata;
                end
                else
                begin
                    hit_next    = 1'b0;
                    hitval_next = ram_rdata;
                end
                state_next = ST_C3;
            end
            ST_C3:
            begin
                // hold the read address until the output slot frees
                ram_raddr = t_reg;
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = j_reg;
                    ram_wdata      = si_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = data_reg ^ (hit_reg ? hitval_reg : ram_rdata);
                    state_next     = ST_IDLE;
                end
            end
            ST_K0:
            begin
                ram_raddr  = cnt_reg;
                state_next = ST_K1;
            end
            ST_K1:
            begin
                // j += perm[k] + key[k mod len]; fetch perm[j]
                si_next    = ram_rdata;
                j_next     = j_reg + ram_rdata + key_bytes[kidx_reg];
                ram_raddr  = j_reg + ram_rdata + key_bytes[kidx_reg];
                state_next = ST_K2;
            end
            ST_K2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_K3;
            end
            ST_K3:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                cnt_next  = cnt_reg + 1'b1;
                kidx_next = (kidx_reg == kidx_last) ? '0 : kidx_reg + 1'b1;
                if (cnt_reg == rc4sc_pkg::PERM_LAST)
                begin
                    j_next     = '0;
                    rekey_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_K0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            kidx_reg      <= '0;
            rekey_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            kidx_reg      <= kidx_next;
            rekey_reg     <= rekey_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        t_reg        <= t_next;
        hit_reg      <= hit_next;
        hitval_reg   <= hitval_next;
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg  <= '0;
            key_hi_reg  <= '0;
            key_len_reg <= rc4sc_pkg::KEY_LEN_W'(5);
        end
        else if (cfg_we)
        begin
            priority if (cfg_addr == rc4sc_pkg::CFG_KEY_LOW)
            begin
                key_lo_reg <= cfg_wdata;
            end
            else if (cfg_addr == rc4sc_pkg::CFG_KEY_HIGH)
            begin
                key_hi_reg <= cfg_wdata;
            end
            else if (cfg_addr == rc4sc_pkg::CFG_KEY_LEN)
            begin
                key_len_reg <= cfg_wdata[rc4sc_pkg::KEY_LEN_W-1:0];
            end
        end
    end

    // Checks
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("permutation written while idle");

    a_fill_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (ram_we && (ram_waddr == ram_wdata)))
        else $error("fill pass wrote a non-identity entry");

    a_crypt_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_C3 && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("crypt step finished without a result");

    a_rekey_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K3 && cnt_reg == rc4sc_pkg::PERM_LAST)
        |=> (i_reg == '0 && j_reg == '0 && !rekey_reg && state_reg == ST_IDLE))
        else $error("key schedule ended with indices not cleared");

endmodule
`default_nettype wire

### dv/tb_rc4_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc4_stream_cipher
// Self-checking bench for the RC4 stream engine. A class keeps its own copy
// of the permutation, the indices and the key registers. It predicts every
// output byte from the input beats as they are accepted, and checks the
// output beats in order. A directed opening covers the reset state, the key
// length limits, the unused register index and repeated rekeys. Random key
// settings follow under four flow-control phases.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 3;
    localparam int REKEY_CYCLES    = 1400;     // full key schedule plus margin
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int PHASES          = 4;

    // address with no register behind it
    localparam logic [rc4sc_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    // sender idle and receiver stall rates per phase, percent of cycles
    localparam int SEND_PCT [PHASES] = '{0, 86, 0, 11};
    localparam int RECV_PCT [PHASES] = '{0, 0, 86, 11};

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [rc4sc_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
    logic [rc4sc_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [7:0]                           s_axis_tdata = '0;   // [7:0] data_in
    logic                                 s_axis_tuser = 1'b0; // [0] opcode
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [7:0]                           m_axis_tdata;        // [7:0] data_out

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    key_settings = 0;
    int unsigned           cycles = 0;

    rc4_stream_cipher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Cipher state mirror and queue of expected output bytes
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        rc4sc_pkg::byte_t  perm [rc4sc_pkg::PERM_DEPTH];
        rc4sc_pkg::byte_t  idx_i;
        rc4sc_pkg::byte_t  idx_j;
        logic [63:0]       key_lo;
        logic [63:0]       key_hi;
        logic [4:0]        key_len;
        rc4sc_pkg::byte_t  cipher_q [$];
        int                errors;
        int                n_crypt;
        int                n_rekey;
        int                n_checked;

        function new();
            for (int k = 0; k < rc4sc_pkg::PERM_DEPTH; k++)
                perm[k] = rc4sc_pkg::byte_t'(k);
            idx_i     = '0;
            idx_j     = '0;
            key_lo    = '0;
            key_hi    = '0;
            key_len   = 5'd5;
            errors    = 0;
            n_crypt   = 0;
            n_rekey   = 0;
            n_checked = 0;
        endfunction

        function void write_reg(logic [rc4sc_pkg::CFG_ADDR_W-1:0] addr,
                                logic [rc4sc_pkg::CFG_DATA_W-1:0] val);
            case (addr)
                rc4sc_pkg::CFG_KEY_LOW:  key_lo  = val;
                rc4sc_pkg::CFG_KEY_HIGH: key_hi  = val;
                rc4sc_pkg::CFG_KEY_LEN:  key_len = val[4:0];
                default:                 ;
            endcase
        endfunction

        function rc4sc_pkg::byte_t key_byte(int k);
            return (k < 8) ? key_lo[8*k +: 8] : key_hi[8*(k-8) +: 8];
        endfunction

        // Rebuild the permutation from the current key, then clear both indices
        function void schedule_key();
            int                n;
            rc4sc_pkg::byte_t  j;
            rc4sc_pkg::byte_t  t;
            n = (key_len == 0) ? 1 : int'(key_len);
            if (n > rc4sc_pkg::MAX_KEY_BYTES)
                n = rc4sc_pkg::MAX_KEY_BYTES;
            for (int k = 0; k < rc4sc_pkg::PERM_DEPTH; k++)
                perm[k] = rc4sc_pkg::byte_t'(k);
            j = '0;
            for (int k = 0; k < rc4sc_pkg::PERM_DEPTH; k++)
            begin
                j       = j + perm[k] + key_byte(k % n);
                t       = perm[k];
                perm[k] = perm[j];
                perm[j] = t;
            end
            idx_i = '0;
            idx_j = '0;
        endfunction

        // Step the generator once and mix the keystream byte into d
        function rc4sc_pkg::byte_t next_cipher_byte(rc4sc_pkg::byte_t d);
            rc4sc_pkg::byte_t t;
            idx_i       = idx_i + 8'd1;
            idx_j       = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            t           = perm[idx_i] + perm[idx_j];
            return d ^ perm[t];
        endfunction

        function void note_input(logic op, rc4sc_pkg::byte_t d);
            if (op == rc4sc_pkg::OP_REKEY)
            begin
                schedule_key();
                n_rekey++;
            end
            else
            begin
                cipher_q.push_back(next_cipher_byte(d));
                n_crypt++;
            end
        endfunction

        function void check_result(rc4sc_pkg::byte_t got);
            rc4sc_pkg::byte_t want;
            if (cipher_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output beat, expected none, actual 0x%02h",
                         $time, got);
                return;
            end
            want = cipher_q.pop_front();
            n_checked++;
            if (got !== want)
            begin
                errors++;
                $display("%0t: data_out mismatch, expected 0x%02h, actual 0x%02h",
                         $time, want, got);
            end
        endfunction
    endclass

    cipher_scoreboard sb = new();

    // Clock
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Random backpressure on the output side
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check every accepted output beat
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d bytes pending",
                     cycles, sb.cipher_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one beat, idling first at the current rate; hold until accepted
    task automatic send_beat(logic op, rc4sc_pkg::byte_t d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(op, d);
    endtask

    // Drop valid, drain the output, then let a possible rekey run out
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.cipher_q.size() != 0)
            @(posedge clk);
        repeat (REKEY_CYCLES) @(posedge clk);
    endtask

    // Write the three key registers, optionally poking the unused index too
    task automatic load_key(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_word,
                            bit poke_unused);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_addr  <= rc4sc_pkg::CFG_KEY_LOW;
        cfg_wdata <= lo;
        @(posedge clk);
        sb.write_reg(rc4sc_pkg::CFG_KEY_LOW, lo);
        cfg_addr  <= rc4sc_pkg::CFG_KEY_HIGH;
        cfg_wdata <= hi;
        @(posedge clk);
        sb.write_reg(rc4sc_pkg::CFG_KEY_HIGH, hi);
        cfg_addr  <= rc4sc_pkg::CFG_KEY_LEN;
        cfg_wdata <= len_word;
        @(posedge clk);
        sb.write_reg(rc4sc_pkg::CFG_KEY_LEN, len_word);
        if (poke_unused)
        begin
            cfg_addr  <= CFG_UNUSED;
            cfg_wdata <= junk;
            @(posedge clk);
            sb.write_reg(CFG_UNUSED, junk);
        end
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    // Stimulus
    initial
    begin
        int          block_len;
        int          sent;
        logic [4:0]  len5;
        logic [63:0] len_word;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // crypt on the reset permutation, no rekey yet
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'hFF);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h5A);
        // default key of five zero bytes; data is ignored on rekey
        send_beat(rc4sc_pkg::OP_REKEY, 8'hFF);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'hFF);

        // zero key length acts as one byte
        settle_idle();
        load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd0, 1'b1);
        send_beat(rc4sc_pkg::OP_REKEY, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'hFF);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h3C);

        // full sixteen-byte key, all ones
        settle_idle();
        load_key('1, '1, 64'd16, 1'b0);
        send_beat(rc4sc_pkg::OP_REKEY, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'hC3);

        // lengths past the limit saturate
        settle_idle();
        load_key(64'hA5A5_5A5A_0F0F_F0F0, 64'h1122_3344_5566_7788, 64'd17, 1'b0);
        send_beat(rc4sc_pkg::OP_REKEY, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'hFF);
        settle_idle();
        load_key(64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 64'd31, 1'b0);
        send_beat(rc4sc_pkg::OP_REKEY, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h00);

        // one-byte key, back-to-back rekeys
        settle_idle();
        load_key(64'h0000_0000_0000_00FF, '0, 64'd1, 1'b0);
        send_beat(rc4sc_pkg::OP_REKEY, 8'h00);
        send_beat(rc4sc_pkg::OP_REKEY, 8'h80);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'h00);
        send_beat(rc4sc_pkg::OP_CRYPT, 8'hFF);

        // Random key settings under each flow-control phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                block_len = $urandom_range(30, 90);
                settle_idle();
                if ($urandom_range(0, 5) == 0)
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                else
                begin
                    send_idle_pct  = SEND_PCT[ph];
                    recv_stall_pct = RECV_PCT[ph];
                end
                len5 = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 16));
                len_word      = {$urandom, $urandom};
                len_word[4:0] = len5;
                if ($urandom_range(0, 3) != 0)
                    len_word[63:5] = '0;
                load_key({$urandom, $urandom}, {$urandom, $urandom}, len_word,
                         $urandom_range(0, 7) == 0);
                // mostly rekey right away; sometimes keep the old permutation
                if ($urandom_range(0, 7) != 0)
                begin
                    send_beat(rc4sc_pkg::OP_REKEY, rc4sc_pkg::byte_t'($urandom));
                    sent++;
                end
                for (int n = 0; n < block_len; n++)
                begin
                    if ($urandom_range(0, 49) == 0)
                        send_beat(rc4sc_pkg::OP_REKEY, rc4sc_pkg::byte_t'($urandom));
                    else
                        send_beat(rc4sc_pkg::OP_CRYPT, rc4sc_pkg::byte_t'($urandom));
                end
                sent += block_len;
            end
        end

        // Drain and report
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle_idle();
        $display("Sent %0d crypt beats and %0d rekeys over %0d key settings;",
                 sb.n_crypt, sb.n_rekey, key_settings);
        $display("checked %0d output beats under four flow-control phases, %0d errors.",
                 sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.cipher_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
